FILE: rtl/core/jse_pkg.sv
// Shared types, constants and helpers for the JSON string escaper.
`timescale 1ns / 1ps
package jse_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  // Output slots of one item: open quote, up to six escape bytes, close quote.
  localparam logic [2:0] SLOT_OPEN   = 3'd0;
  localparam logic [2:0] SLOT_FIRST  = 3'd1;
  localparam logic [2:0] SLOT_SECOND = 3'd2;
  localparam logic [2:0] SLOT_ZERO_A = 3'd3;
  localparam logic [2:0] SLOT_ZERO_B = 3'd4;
  localparam logic [2:0] SLOT_HEX_HI = 3'd5;
  localparam logic [2:0] SLOT_HEX_LO = 3'd6;
  localparam logic [2:0] SLOT_CLOSE  = 3'd7;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNICODE
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       starts_string;
    logic       ends_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_item_t;

  // Classified item: which slots emit, and what the escape slots need.
  typedef struct packed {
    logic [7:0] mask;
    kind_t      kind;
    logic [7:0] data;
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = CH_ZERO + {4'd0, n};
    else c = CH_LOWA + {4'd0, n} - 8'd10;
    return c;
  endfunction

  function automatic logic [7:0] slot_byte(input kind_t kind, input logic [7:0] data,
                                           input logic [2:0] slot);
    logic [7:0] c;
    c = CH_QUOTE;
    case (slot)
      SLOT_OPEN, SLOT_CLOSE: c = CH_QUOTE;
      SLOT_FIRST:  c = (kind == KIND_PLAIN) ? data : CH_BSLASH;
      SLOT_SECOND: c = (kind == KIND_UNICODE) ? CH_U : data;
      SLOT_ZERO_A, SLOT_ZERO_B: c = CH_ZERO;
      SLOT_HEX_HI: c = hex_char(data[7:4]);
      SLOT_HEX_LO: c = hex_char(data[3:0]);
      default: c = CH_QUOTE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/jse_front.sv
// Front end: accept items, classify the byte and build a slot descriptor.
`timescale 1ns / 1ps
module jse_front import jse_pkg::*; (
  input  logic     src_valid,
  output logic     src_stall,
  input  in_item_t src_item,
  input  logic     q_full,
  output logic     push,
  output desc_t    push_desc
);

  kind_t      kind;
  logic [7:0] data;
  logic [7:0] mid;

  always_comb begin
    kind = KIND_PLAIN;
    data = src_item.in_byte;
    unique case (src_item.in_byte)
      8'h22: data = CH_QUOTE;
      8'h5C: data = CH_BSLASH;
      8'h0A: data = 8'h6E;
      8'h0D: data = 8'h72;
      8'h09: data = 8'h74;
      8'h08: data = 8'h62;
      8'h0C: data = 8'h66;
      default: data = src_item.in_byte;
    endcase
    if (src_item.in_byte == 8'h22 || src_item.in_byte == 8'h5C ||
        src_item.in_byte == 8'h0A || src_item.in_byte == 8'h0D ||
        src_item.in_byte == 8'h09 || src_item.in_byte == 8'h08 ||
        src_item.in_byte == 8'h0C) begin
      kind = KIND_SHORT;
    end else if (src_item.in_byte < CTRL_TOP) begin
      kind = KIND_UNICODE;
    end
    if (!src_item.has_byte) kind = KIND_NONE;

    unique case (kind)
      KIND_PLAIN:   mid = 8'b0000_0010;
      KIND_SHORT:   mid = 8'b0000_0110;
      KIND_UNICODE: mid = 8'b0111_1110;
      default:      mid = 8'b0000_0000;
    endcase
    push_desc.mask = mid | {src_item.ends_string, 6'd0, src_item.starts_string};
    push_desc.kind = kind;
    push_desc.data = data;
  end

  assign src_stall = q_full;
  // Drop items that produce nothing; they never enter the queue.
  assign push = src_valid && !q_full && (push_desc.mask != 8'd0);

endmodule

FILE: rtl/core/jse_queue.sv
// Small descriptor queue between the front end and the serializer.
`timescale 1ns / 1ps
module jse_queue import jse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  full,
  output logic  empty
);

  desc_t          mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/core/jse_back.sv
// Back end: walk each descriptor's slots and drive one output byte per cycle while the output is not stalled.
`timescale 1ns / 1ps
module jse_back import jse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  desc_t     head,
  input  logic      empty,
  output logic      pop,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_item_t dst_item
);

  logic [7:0] rem;
  kind_t      kind;
  logic [7:0] data;

  logic [7:0] cur_mask;
  kind_t      cur_kind;
  logic [7:0] cur_data;
  logic [7:0] rem_next;
  logic [2:0] slot;
  logic       avail;
  logic       advance;

  always_comb begin
    if (rem != 8'd0) begin
      cur_mask = rem;
      cur_kind = kind;
      cur_data = data;
    end else begin
      cur_mask = head.mask;
      cur_kind = head.kind;
      cur_data = head.data;
    end
    slot = SLOT_CLOSE;
    for (int i = 7; i >= 0; i--) begin
      if (cur_mask[i]) slot = 3'(i);
    end
    rem_next = cur_mask & (cur_mask - 8'd1);
  end

  assign avail   = (rem != 8'd0) || !empty;
  assign advance = avail && (!dst_valid || !dst_stall);
  assign pop     = advance && (rem == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      dst_valid <= 1'b0;
    end else begin
      if (advance) begin
        rem       <= rem_next;
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head.kind;
      data <= head.data;
    end
    if (advance) begin
      dst_item.out_byte   <= slot_byte(cur_kind, cur_data, slot);
      dst_item.run_end    <= (rem_next == 8'd0);
      dst_item.string_end <= (slot == SLOT_CLOSE);
    end
  end

endmodule

FILE: rtl/core/json_string_escaper.sv
// JSON string escaper: an accepted item is written into the queue, and its first output byte
// is then registered in the output register. Output runs at one byte per cycle while the
// receiver does not stall; an item produces 1 to 8 bytes, and items with nothing to emit
// never enter the queue. Input takes one item per cycle while the 4-entry queue has room.
// Synchronous reset empties the queue and the output register; no clearing pass.
`timescale 1ns / 1ps
module json_string_escaper import jse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_item,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_item_t dst_item
);

  logic  push;
  desc_t push_desc;
  logic  pop;
  desc_t head;
  logic  q_full;
  logic  q_empty;

  jse_front u_front (
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  jse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  jse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

endmodule

FILE: rtl/core/jse_checker.sv
// Port-level checks for the JSON string escaper, bound to the top level.
`timescale 1ns / 1ps
module jse_checker import jse_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      src_valid,
  input logic      src_stall,
  input in_item_t  src_item,
  input logic      dst_valid,
  input logic      dst_stall,
  input out_item_t dst_item
);

  // Hold a stalled output item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("stalled output item changed");

  // Hold a stalled input item.
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_item))
    else $error("stalled input item changed");

  // Closing quote always ends the run of its item.
  a_close: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.string_end |->
      dst_item.out_byte == CH_QUOTE && dst_item.run_end)
    else $error("closing quote malformed");

  a_rst_out: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("output valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !src_stall)
    else $error("input stalled right after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_item  (src_item),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the JSON string escaper: directed table, random strings, noise.
`timescale 1ns / 1ps
module tb_top;
  import jse_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_AFTER   = 440;
  localparam int HANG_LIMIT   = 2000;

  typedef struct packed {
    in_item_t    item;
    logic        typed;
    logic [3:0]  count;
    logic [63:0] text;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  in_item_t  src_item = '0;
  logic      dst_valid;
  logic      dst_stall = 1'b0;
  out_item_t dst_item;

  // Typed expectation that rides along with the item on the input channel.
  logic        src_typed = 1'b0;
  logic [3:0]  src_count = '0;
  logic [63:0] src_text = '0;

  out_item_t escaped_q[$];
  row_t      stim_rows[$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  int        stall_left = 0;

  json_string_escaper u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h57 + {4'd0, v};
  endfunction

  // Expand one item into its escaped JSON bytes and queue them.
  function automatic void queue_escaped(in_item_t it);
    logic [7:0] txt [0:7];
    logic [7:0] pair;
    out_item_t  o;
    int         n;
    n = 0;
    pair = 8'h00;
    if (it.starts_string) begin
      txt[n] = CH_QUOTE;
      n++;
    end
    if (it.has_byte) begin
      case (it.in_byte)
        8'h22: pair = 8'h22;
        8'h5C: pair = 8'h5C;
        8'h0A: pair = 8'h6E;
        8'h0D: pair = 8'h72;
        8'h09: pair = 8'h74;
        8'h08: pair = 8'h62;
        8'h0C: pair = 8'h66;
        default: pair = 8'h00;
      endcase
      if (pair != 8'h00) begin
        txt[n] = CH_BSLASH;
        txt[n + 1] = pair;
        n += 2;
      end else if (it.in_byte < CTRL_TOP) begin
        txt[n] = CH_BSLASH;
        txt[n + 1] = CH_U;
        txt[n + 2] = CH_ZERO;
        txt[n + 3] = CH_ZERO;
        txt[n + 4] = hex_digit(it.in_byte[7:4]);
        txt[n + 5] = hex_digit(it.in_byte[3:0]);
        n += 6;
      end else begin
        txt[n] = it.in_byte;
        n++;
      end
    end
    if (it.ends_string) begin
      txt[n] = CH_QUOTE;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      o.out_byte = txt[i];
      o.run_end = (i == n - 1);
      o.string_end = it.ends_string && (i == n - 1);
      escaped_q.push_back(o);
    end
  endfunction

  function automatic void add_row(in_item_t it, logic typed, logic [3:0] cnt,
                                  logic [63:0] txt);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.count = cnt;
    r.text = txt;
    stim_rows.push_back(r);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: b = 8'($urandom_range(0, 31));
      3:       b = $urandom_range(0, 1) ? 8'h22 : 8'h5C;
      4, 5:    b = 8'($urandom_range(128, 255));
      default: b = 8'($urandom_range(32, 127));
    endcase
    return b;
  endfunction

  task automatic send(row_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= r.item;
    src_typed <= r.typed;
    src_count <= r.count;
    src_text  <= r.text;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  // Hold the input low until every queued byte has come out.
  task automatic drain();
    src_valid <= 1'b0;
    do @(posedge clk); while (escaped_q.size() != 0);
  endtask

  // Receiver: stall in random bursts until the calm tail.
  always @(posedge clk) begin
    if (rst) begin
      dst_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      dst_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      dst_stall <= 1'b1;
      stall_left <= $urandom_range(1, 14) - 1;
    end else begin
      dst_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t o;
    if (!rst) begin
      if (src_valid && !src_stall) begin
        if (src_typed) begin
          for (int i = 0; i < src_count; i++) begin
            o.out_byte = src_text[63 - 8 * i -: 8];
            o.run_end = (i == src_count - 1);
            o.string_end = src_item.ends_string && (i == src_count - 1);
            escaped_q.push_back(o);
          end
        end else begin
          queue_escaped(src_item);
        end
      end
      if (dst_valid && !dst_stall) begin
        if (escaped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected byte %h run_end %b string_end %b", dst_item.out_byte,
                     dst_item.run_end, dst_item.string_end);
        end else begin
          want = escaped_q.pop_front();
          if (dst_item.out_byte !== want.out_byte || dst_item.run_end !== want.run_end ||
              dst_item.string_end !== want.string_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %h run_end %b string_end %b, got %h %b %b",
                       want.out_byte, want.run_end, want.string_end, dst_item.out_byte,
                       dst_item.run_end, dst_item.string_end);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t     r;
    in_item_t it;
    int       sent;
    int       len;
    bit       paused;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty string, nothing to do, ignored byte, lone quotes.
    add_row({8'h00, 1'b0, 1'b1, 1'b1}, 1'b1, 4'd2, 64'h2222_0000_0000_0000);
    add_row({8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, 4'd0, 64'h0);
    add_row({8'hFF, 1'b0, 1'b0, 1'b0}, 1'b1, 4'd0, 64'h0);
    add_row({8'h5C, 1'b0, 1'b1, 1'b0}, 1'b1, 4'd1, 64'h2200_0000_0000_0000);
    add_row({8'h00, 1'b0, 1'b0, 1'b1}, 1'b1, 4'd1, 64'h2200_0000_0000_0000);
    // Byte extremes and control range edges.
    add_row({8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd6, 64'h5C75_3030_3030_0000);
    add_row({8'h1F, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd6, 64'h5C75_3030_3166_0000);
    add_row({8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd1, 64'hFF00_0000_0000_0000);
    add_row({8'h20, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd1, 64'h2000_0000_0000_0000);
    add_row({8'h7F, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd1, 64'h7F00_0000_0000_0000);
    add_row({8'h80, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd1, 64'h8000_0000_0000_0000);
    // Escaped quote before the closing one: only the last carries string_end; then the other short escapes.
    add_row({8'h22, 1'b1, 1'b0, 1'b1}, 1'b1, 4'd3, 64'h5C22_2200_0000_0000);
    add_row({8'h5C, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd2, 64'h5C5C_0000_0000_0000);
    add_row({8'h0A, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd2, 64'h5C6E_0000_0000_0000);
    add_row({8'h0D, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd2, 64'h5C72_0000_0000_0000);
    add_row({8'h09, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd2, 64'h5C74_0000_0000_0000);
    add_row({8'h08, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd2, 64'h5C62_0000_0000_0000);
    add_row({8'h0C, 1'b1, 1'b0, 1'b0}, 1'b1, 4'd2, 64'h5C66_0000_0000_0000);
    // Longest run: both quotes around a unicode escape; then untyped rows checked by queue_escaped.
    add_row({8'h01, 1'b1, 1'b1, 1'b1}, 1'b1, 4'd8, 64'h225C_7530_3030_3122);
    add_row({8'h1A, 1'b1, 1'b1, 1'b0}, 1'b0, 4'd0, 64'h0);
    add_row({8'h0B, 1'b1, 1'b0, 1'b0}, 1'b0, 4'd0, 64'h0);
    add_row({8'h41, 1'b1, 1'b0, 1'b1}, 1'b0, 4'd0, 64'h0);
    add_row({8'hE9, 1'b1, 1'b1, 1'b1}, 1'b0, 4'd0, 64'h0);
    add_row({8'h7E, 1'b1, 1'b0, 1'b0}, 1'b0, 4'd0, 64'h0);

    foreach (stim_rows[i]) send(stim_rows[i]);
    drain();

    // Mostly well-formed strings with random content, some noise items.
    sent = 0;
    paused = 1'b0;
    r = '0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        it = in_item_t'($urandom);
        r.item = it;
        send(r);
        if (it.has_byte || it.starts_string || it.ends_string) sent++;
      end else begin
        len = $urandom_range(0, 8);
        if (len == 0) begin
          r.item = {pick_byte(), 1'b0, 1'b1, 1'b1};
          send(r);
          sent++;
        end else begin
          for (int i = 0; i < len; i++) begin
            r.item = {pick_byte(), 1'b1, i == 0, i == len - 1};
            send(r);
            sent++;
          end
        end
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      calm = (sent >= CALM_AFTER);
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && escaped_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escaper.sv
rtl/core/jse_checker.sv
tb/tb_top.sv
